// ===== sv/heartbeat_liveness_tracker_core_assert.svh =====
// ----------------------------------------------------------------------------
// Heartbeat liveness tracker assertion macros
// Shorthand for clocked checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_LIVENESS_TRACKER_CORE_ASSERT_SVH
`define HEARTBEAT_LIVENESS_TRACKER_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HLT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define HLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hblt_pkg.sv =====
// ----------------------------------------------------------------------------
// hblt_pkg
// Shared codes, widths and inter-module types of the liveness tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package hblt_pkg;

    localparam int MASK_W    = 32;
    localparam int TICK_W    = 16;
    localparam int STEP_W    = 4;   // counts TICK_W remainder steps
    localparam int THR_W     = 8;
    localparam int WORKER_W  = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 72;

    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_PROBE = 2'd1;
    localparam logic [1:0] CMD_START = 2'd2;

    localparam logic [1:0] LV_UNKNOWN   = 2'd0;
    localparam logic [1:0] LV_ALIVE     = 2'd1;
    localparam logic [1:0] LV_SUSPECTED = 2'd2;
    localparam logic [1:0] LV_DEAD      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_SUSPECT_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_THR    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECHECK     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MONITORED   = 2'd3;

    typedef struct packed {
        logic              start;
        logic [TICK_W-1:0] dividend;
        logic [TICK_W-1:0] divisor;
    } hblt_mod_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [TICK_W-1:0] rem;
    } hblt_mod_rsp_t;

endpackage

`default_nettype wire

// ===== sv/hblt_ram.sv =====
// ----------------------------------------------------------------------------
// hblt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hblt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== sv/hblt_mod.sv =====
// ----------------------------------------------------------------------------
// hblt_mod
// Bit-serial remainder unit: tick count modulo recheck interval,
// one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hblt_mod (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hblt_pkg::hblt_mod_req_t req,
    output hblt_pkg::hblt_mod_rsp_t rsp
);

    localparam int TW = hblt_pkg::TICK_W;
    localparam int SW = hblt_pkg::STEP_W;

    logic          busy_reg, busy_next;
    logic [SW-1:0] step_reg, step_next;
    logic [TW-1:0] num_reg, num_next;
    logic [TW-1:0] den_reg, den_next;
    logic [TW-1:0] rem_reg, rem_next;
    logic [TW:0]   trial;
    logic [TW-1:0] rem_step;
    logic          last_step;

    always_comb begin
        trial = {rem_reg, num_reg[TW-1]};
        if (trial >= {1'b0, den_reg}) begin
            trial = trial - {1'b0, den_reg};
        end
        rem_step  = trial[TW-1:0];
        last_step = (step_reg == SW'(TW - 1));
    end

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (req.start) begin
            busy_next = 1'b1;
            step_next = '0;
            num_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            num_next  = num_reg << 1;
            rem_next  = rem_step;
            step_next = step_reg + SW'(1);
            if (last_step) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = busy_reg && last_step;
    assign rsp.rem  = rem_step;

endmodule

`default_nettype wire

// ===== sv/heartbeat_liveness_tracker_core.sv =====
// ----------------------------------------------------------------------------
// heartbeat_liveness_tracker_core
// Per-worker liveness states and saturating miss counters; miss counters
// live in a RAM and are updated by read-modify-write on probe results.
// ----------------------------------------------------------------------------
//  channel | direction | beat content
//  s_      | in        | tuser: cmd; tdata: worker, probe_alive
//  m_      | out       | tuser: changed; tdata: worker, state, probe/dead masks
//  cfg_    | in        | cfg_index, cfg_data register write
//
//  Tick, start and unused commands: result registered at accept.
//  Probe result: miss RAM read, then update and write-back (ST_UPDATE).
//  Writing the recheck interval starts a remainder pass; input and
//  config stall until it finishes. No clearing pass after reset: counter
//  valid bits are cleared by reset itself. Input is taken when the output register
//  is empty or drains in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module heartbeat_liveness_tracker_core #(
    parameter int NUM_WORKERS = 32,
    parameter int MISS_BITS   = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: worker[4:0], probe_alive[5], zero[7:6]
    input  logic [hblt_pkg::S_DATA_W-1:0]       s_tdata,
    // s_tuser: cmd[1:0]
    input  logic [1:0]                          s_tuser,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // m_tdata: changed_worker[4:0], state[6:5], probe_mask[38:7],
    //          dead_mask[70:39], zero[71]
    output logic [hblt_pkg::M_DATA_W-1:0]       m_tdata,
    // m_tuser: changed[0]
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [hblt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hblt_pkg::CFG_W-1:0]          cfg_data
);

    localparam int AW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int CW = (MISS_BITS > hblt_pkg::THR_W) ? MISS_BITS : hblt_pkg::THR_W;
    localparam int MW = hblt_pkg::MASK_W;
    localparam int TW = hblt_pkg::TICK_W;
    localparam int WW = hblt_pkg::WORKER_W;
    localparam logic [WW+1:0] NW = (WW + 2)'(NUM_WORKERS);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    // configuration
    logic [hblt_pkg::THR_W-1:0] susp_thr_reg, dead_thr_reg;
    logic [TW-1:0]              interval_reg;
    logic [MW-1:0]              mon_mask_reg;

    // state
    logic                   state_reg, state_next;
    logic [TW-1:0]          tick_reg, tick_next;
    logic [TW-1:0]          phase_reg, phase_next;
    logic [NUM_WORKERS-1:0] alive_reg, alive_next;
    logic [NUM_WORKERS-1:0] susp_reg, susp_next;
    logic [NUM_WORKERS-1:0] dead_reg, dead_next;
    logic [NUM_WORKERS-1:0] cval_reg, cval_next;
    logic [NUM_WORKERS-1:0] mon_vec;
    logic [WW-1:0]          pw_reg, pw_next;
    logic                   pok_reg, pok_next;

    // output register
    logic                          m_tvalid_reg, m_tvalid_next;
    logic [hblt_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                          m_tuser_reg, m_tuser_next;

    // datapath
    logic [1:0]           in_cmd;
    logic [WW-1:0]        in_worker;
    logic                 in_ok;
    logic                 in_fire, out_fire, cfg_fire;
    logic                 recheck;
    logic [MW-1:0]        probe_mask, dead_out;
    logic                 pw_ok, apply;
    logic [AW-1:0]        pa;
    logic [1:0]           st_cur, target;
    logic [MISS_BITS-1:0] miss_old, miss_inc, miss_new;
    logic                 ram_we;
    logic [MISS_BITS-1:0] ram_rdata;
    logic [TW-1:0]        tick_inc;

    hblt_pkg::hblt_mod_req_t mod_req;
    hblt_pkg::hblt_mod_rsp_t mod_rsp;

    assign in_cmd    = s_tuser;
    assign in_worker = s_tdata[WW-1:0];
    assign in_ok     = s_tdata[WW];

    assign s_tready  = (state_reg == ST_IDLE) && !mod_rsp.busy && (!m_tvalid_reg || m_tready);
    assign cfg_ready = (state_reg == ST_IDLE) && !mod_rsp.busy;
    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid_reg && m_tready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // remainder unit keeps phase_reg equal to tick count mod interval;
    // dividend is the count as it stands after this edge
    assign mod_req.start    = cfg_fire && (cfg_index == hblt_pkg::REG_RECHECK);
    assign mod_req.dividend = tick_next;
    assign mod_req.divisor  = cfg_data[TW-1:0];

    hblt_mod u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mod_req),
        .rsp     (mod_rsp)
    );

    hblt_ram #(
        .WIDTH (MISS_BITS),
        .DEPTH (NUM_WORKERS)
    ) u_miss_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pa),
        .wdata (miss_new),
        .re    (in_fire),
        .raddr (AW'(in_worker)),
        .rdata (ram_rdata)
    );

    // per-bit mask views, workers at or above NUM_WORKERS read as zero
    genvar g;
    for (g = 0; g < MW; g++) begin : g_mask
        if (g < NUM_WORKERS) begin : g_on
            assign probe_mask[g] = alive_reg[g] | susp_reg[g] | (dead_reg[g] & recheck);
            assign dead_out[g]   = dead_next[g];
        end else begin : g_off
            assign probe_mask[g] = 1'b0;
            assign dead_out[g]   = 1'b0;
        end
    end
    for (g = 0; g < NUM_WORKERS; g++) begin : g_mon
        if (g < MW) begin : g_on
            assign mon_vec[g] = mon_mask_reg[g];
        end else begin : g_off
            assign mon_vec[g] = 1'b0;
        end
    end

    // tick phase tracking
    always_comb begin
        tick_inc = tick_reg + TW'(1);
        if (tick_inc == '0) begin
            phase_next = '0;
        end else if ((phase_reg + TW'(1)) == interval_reg) begin
            phase_next = '0;
        end else begin
            phase_next = phase_reg + TW'(1);
        end
        recheck = (interval_reg != '0) && (phase_next == '0);
    end

    // probe result update, valid in ST_UPDATE
    always_comb begin
        pw_ok    = ({2'b00, pw_reg} < NW);
        pa       = AW'(pw_reg);
        st_cur   = {susp_reg[pa] | dead_reg[pa], alive_reg[pa] | dead_reg[pa]};
        miss_old = cval_reg[pa] ? ram_rdata : '0;
        miss_inc = (&miss_old) ? miss_old : miss_old + MISS_BITS'(1);
        miss_new = pok_reg ? '0 : miss_inc;
        if (pok_reg) begin
            target = hblt_pkg::LV_ALIVE;
        end else if (CW'(miss_inc) >= CW'(dead_thr_reg)) begin
            target = hblt_pkg::LV_DEAD;
        end else if (CW'(miss_inc) >= CW'(susp_thr_reg)) begin
            target = hblt_pkg::LV_SUSPECTED;
        end else begin
            target = st_cur;
        end
        apply  = (state_reg == ST_UPDATE) && pw_ok && (st_cur != hblt_pkg::LV_UNKNOWN);
        ram_we = apply;
    end

    always_comb begin
        state_next    = state_reg;
        tick_next     = tick_reg;
        alive_next    = alive_reg;
        susp_next     = susp_reg;
        dead_next     = dead_reg;
        cval_next     = cval_reg;
        pw_next       = pw_reg;
        pok_next      = pok_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tuser_next  = m_tuser_reg;
        if (mod_rsp.done) begin
            tick_next = tick_reg;
        end
        if (out_fire) begin
            m_tvalid_next = 1'b0;
        end
        if (state_reg == ST_UPDATE) begin
            state_next    = ST_IDLE;
            m_tvalid_next = 1'b1;
            m_tuser_next  = 1'b0;
            if (apply) begin
                cval_next[pa] = 1'b1;
                if (target != st_cur) begin
                    alive_next[pa] = (target == hblt_pkg::LV_ALIVE);
                    susp_next[pa]  = (target == hblt_pkg::LV_SUSPECTED);
                    dead_next[pa]  = (target == hblt_pkg::LV_DEAD);
                    m_tuser_next   = 1'b1;
                end
            end
        end else if (in_fire) begin
            case (in_cmd)
                hblt_pkg::CMD_TICK: begin
                    tick_next = tick_inc;
                end
                hblt_pkg::CMD_PROBE: begin
                    state_next = ST_UPDATE;
                    pw_next    = in_worker;
                    pok_next   = in_ok;
                end
                hblt_pkg::CMD_START: begin
                    alive_next = mon_vec;
                    susp_next  = '0;
                    dead_next  = '0;
                    cval_next  = '0;
                    tick_next  = '0;
                end
                default: begin
                end
            endcase
            if (in_cmd != hblt_pkg::CMD_PROBE) begin
                m_tvalid_next = 1'b1;
                m_tuser_next  = 1'b0;
            end
        end
    end

    // result beat, dead mask taken after this step
    always_comb begin
        m_tdata_next = m_tdata_reg;
        if (state_reg == ST_UPDATE) begin
            m_tdata_next = {1'b0, dead_out, {MW{1'b0}},
                            m_tuser_next ? target : hblt_pkg::LV_UNKNOWN,
                            m_tuser_next ? pw_reg : {WW{1'b0}}};
        end else if (in_fire && in_cmd != hblt_pkg::CMD_PROBE) begin
            m_tdata_next = {1'b0, dead_out,
                            (in_cmd == hblt_pkg::CMD_TICK) ? probe_mask : {MW{1'b0}},
                            hblt_pkg::LV_UNKNOWN, {WW{1'b0}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tick_reg     <= '0;
            phase_reg    <= '0;
            alive_reg    <= '0;
            susp_reg     <= '0;
            dead_reg     <= '0;
            cval_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            susp_thr_reg <= 8'd2;
            dead_thr_reg <= 8'd3;
            interval_reg <= '0;
            mon_mask_reg <= '0;
        end else begin
            state_reg    <= state_next;
            tick_reg     <= tick_next;
            alive_reg    <= alive_next;
            susp_reg     <= susp_next;
            dead_reg     <= dead_next;
            cval_reg     <= cval_next;
            m_tvalid_reg <= m_tvalid_next;
            if (mod_rsp.done) begin
                phase_reg <= mod_rsp.rem;
            end else if (in_fire && in_cmd == hblt_pkg::CMD_TICK) begin
                phase_reg <= phase_next;
            end else if (in_fire && in_cmd == hblt_pkg::CMD_START) begin
                phase_reg <= '0;
            end
            if (cfg_fire) begin
                case (cfg_index)
                    hblt_pkg::REG_SUSPECT_THR: susp_thr_reg <= cfg_data[hblt_pkg::THR_W-1:0];
                    hblt_pkg::REG_DEAD_THR:    dead_thr_reg <= cfg_data[hblt_pkg::THR_W-1:0];
                    hblt_pkg::REG_RECHECK:     interval_reg <= cfg_data[TW-1:0];
                    hblt_pkg::REG_MONITORED:   mon_mask_reg <= cfg_data[MW-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pw_reg      <= pw_next;
        pok_reg     <= pok_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

`include "heartbeat_liveness_tracker_core_assert.svh"

    `HLT_ASSERT_SAME(a_no_accept_while_mod, mod_rsp.busy, !s_tready && !cfg_ready, "item or config accepted during remainder pass")
    `HLT_ASSERT_SAME(a_states_exclusive, 1'b1, ((alive_reg & susp_reg) | (alive_reg & dead_reg) | (susp_reg & dead_reg)) == '0, "worker holds two liveness states")
    `HLT_ASSERT_NEXT(a_probe_to_update, in_fire && in_cmd == hblt_pkg::CMD_PROBE, state_reg == ST_UPDATE, "probe beat did not enter update")
    `HLT_ASSERT_SAME(a_update_slot_free, state_reg == ST_UPDATE, !m_tvalid_reg, "output register busy during update")

endmodule

`default_nettype wire
